FILE: hw/rtl/brf_pkg.sv
// ---------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO
// Sizes, command and status codes, pointer arithmetic helpers.
// ---------------------------------------------------------------------------
package brf_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_BURST = 16;

    localparam int DATA_W  = 8;
    localparam int CMD_W   = 3;
    localparam int OFF_W   = 10;
    localparam int BURST_W = 5;
    localparam int STAT_W  = 2;
    localparam int AMT_W   = 10;
    localparam int FILL_W  = 10;

    localparam int PTR_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CALC_W = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;
    localparam int CNT_W  = $clog2(MAX_BURST + 1);

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CALC_W-1:0] t_calc;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_PUT   = 3'd0;
    localparam t_cmd CMD_GET   = 3'd1;
    localparam t_cmd CMD_PEEK  = 3'd2;
    localparam t_cmd CMD_SKIP  = 3'd3;
    localparam t_cmd CMD_CLEAR = 3'd4;
    localparam t_cmd CMD_QUERY = 3'd5;

    localparam t_status STAT_OK     = 2'd0;
    localparam t_status STAT_FULL   = 2'd1;
    localparam t_status STAT_EMPTY  = 2'd2;
    localparam t_status STAT_OFFSET = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_RDATA
    } t_state;

    // (a + b) mod DEPTH, both operands below DEPTH
    function automatic t_ptr ptr_add(input t_ptr a, input t_calc b);
        logic [CALC_W:0] s;
        s = (CALC_W+1)'(a) + (CALC_W+1)'(b);
        if (s >= (CALC_W+1)'(DEPTH)) begin
            s = s - (CALC_W+1)'(DEPTH);
        end
        return PTR_W'(s);
    endfunction

    // (wp - rp) mod DEPTH
    function automatic t_calc ptr_dist(input t_ptr wp, input t_ptr rp);
        t_calc d;
        if (wp >= rp) begin
            d = CALC_W'(wp) - CALC_W'(rp);
        end else begin
            d = CALC_W'(wp) + CALC_W'(DEPTH) - CALC_W'(rp);
        end
        return d;
    endfunction

endpackage

FILE: hw/rtl/brf_ram.sv
// ---------------------------------------------------------------------------
// brf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/byte_ring_fifo_with_offset_peek_unit.sv
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_offset_peek_unit: byte ring FIFO with offset peek
// Put / get / peek / skip / clear / query on a one-slot-free byte ring.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  command | i_valid / o_stall  | i_cmd i_data_in i_offset i_burst_len
//  result  | o_valid / i_stall  | o_data_out o_data_valid o_last o_status
//          |                    | o_amount o_fill_level
//
//  A command is decoded in its accept cycle and committed in the commit state
//  once the result channel is free. Get/peek with n bytes then send n beats,
//  one byte per cycle unless stalled: the byte store has one read port.
//  Reset clears pointers and fill count; store contents are left as is.
//  A stalled result beat holds the unit in commit or read until it drains.
// ---------------------------------------------------------------------------
module byte_ring_fifo_with_offset_peek_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [brf_pkg::CMD_W-1:0]   i_cmd,
    input  logic [brf_pkg::DATA_W-1:0]  i_data_in,
    input  logic [brf_pkg::OFF_W-1:0]   i_offset,
    input  logic [brf_pkg::BURST_W-1:0] i_burst_len,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [brf_pkg::DATA_W-1:0]  o_data_out,
    output logic                        o_data_valid,
    output logic                        o_last,
    output logic [brf_pkg::STAT_W-1:0]  o_status,
    output logic [brf_pkg::AMT_W-1:0]   o_amount,
    output logic [brf_pkg::FILL_W-1:0]  o_fill_level
);

    brf_pkg::t_state  r_state, n_state;
    brf_pkg::t_ptr    r_wp, n_wp;
    brf_pkg::t_ptr    r_rp, n_rp;
    brf_pkg::t_ptr    r_fill, n_fill;

    brf_pkg::t_cmd    r_cmd, n_cmd;
    logic [brf_pkg::DATA_W-1:0] r_din, n_din;
    brf_pkg::t_status r_status, n_status;
    brf_pkg::t_calc   r_amt, n_amt;
    brf_pkg::t_ptr    r_start, n_start;
    brf_pkg::t_calc   r_avail, n_avail;
    brf_pkg::t_ptr    r_addr, n_addr;
    brf_pkg::t_cnt    r_left, n_left;

    logic                       r_ovalid, n_ovalid;
    logic [brf_pkg::DATA_W-1:0] r_odata, n_odata;
    logic                       r_odv, n_odv;
    logic                       r_olast, n_olast;
    brf_pkg::t_status           r_ostatus, n_ostatus;
    logic [brf_pkg::AMT_W-1:0]  r_oamt, n_oamt;
    logic [brf_pkg::FILL_W-1:0] r_ofill, n_ofill;

    logic                       accept;
    logic                       out_free;
    logic                       is_burst;
    logic                       ram_we;
    logic                       ram_re;
    brf_pkg::t_ptr              ram_raddr;
    logic [brf_pkg::DATA_W-1:0] ram_rdata;

    // decode terms, valid in the accept cycle
    brf_pkg::t_calc fill_w, off_w, burst_w, bsat, avail, nrd, skip_len;
    logic           ovf;

    assign accept   = i_valid && (r_state == brf_pkg::ST_IDLE);
    assign out_free = !r_ovalid || !i_stall;
    assign is_burst = ((r_cmd == brf_pkg::CMD_GET) || (r_cmd == brf_pkg::CMD_PEEK))
                      && (r_status == brf_pkg::STAT_OK) && (r_amt != '0);

    assign fill_w   = brf_pkg::CALC_W'(r_fill);
    assign off_w    = brf_pkg::CALC_W'(i_offset);
    assign burst_w  = brf_pkg::CALC_W'(i_burst_len);
    assign ovf      = off_w > fill_w;
    assign bsat     = (burst_w > brf_pkg::CALC_W'(brf_pkg::MAX_BURST))
                      ? brf_pkg::CALC_W'(brf_pkg::MAX_BURST) : burst_w;
    assign avail    = fill_w - off_w;
    assign nrd      = (bsat < avail) ? bsat : avail;
    assign skip_len = ovf ? fill_w : off_w;

    brf_ram #(
        .WIDTH (brf_pkg::DATA_W),
        .DEPTH (brf_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_din),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = brf_pkg::ST_COMMIT;
                end
            end
            brf_pkg::ST_COMMIT: begin
                if (out_free) begin
                    n_state = is_burst ? brf_pkg::ST_RDATA : brf_pkg::ST_IDLE;
                end
            end
            brf_pkg::ST_RDATA: begin
                if (out_free && (r_left == brf_pkg::CNT_W'(1))) begin
                    n_state = brf_pkg::ST_IDLE;
                end
            end
            default: n_state = brf_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        n_cmd     = r_cmd;
        n_din     = r_din;
        n_status  = r_status;
        n_amt     = r_amt;
        n_start   = r_start;
        n_avail   = r_avail;
        n_addr    = r_addr;
        n_left    = r_left;
        n_ovalid  = r_ovalid && i_stall;
        n_odata   = r_odata;
        n_odv     = r_odv;
        n_olast   = r_olast;
        n_ostatus = r_ostatus;
        n_oamt    = r_oamt;
        n_ofill   = r_ofill;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_start;

        case (r_state)
            brf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_din    = i_data_in;
                    n_avail  = avail;
                    n_status = brf_pkg::STAT_OK;
                    n_amt    = '0;
                    n_start  = brf_pkg::ptr_add(r_rp, off_w);
                    case (i_cmd)
                        brf_pkg::CMD_PUT: begin
                            if (r_fill == brf_pkg::PTR_W'(brf_pkg::DEPTH - 1)) begin
                                n_status = brf_pkg::STAT_FULL;
                            end else begin
                                n_amt = brf_pkg::CALC_W'(1);
                            end
                        end
                        brf_pkg::CMD_GET, brf_pkg::CMD_PEEK: begin
                            if (r_fill == '0) begin
                                n_status = brf_pkg::STAT_EMPTY;
                            end else if (ovf) begin
                                n_status = brf_pkg::STAT_OFFSET;
                            end else begin
                                n_amt = nrd;
                            end
                        end
                        brf_pkg::CMD_SKIP: begin
                            n_start = r_rp;
                            if (r_fill == '0) begin
                                n_status = brf_pkg::STAT_EMPTY;
                            end else begin
                                n_amt = skip_len;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            brf_pkg::ST_COMMIT: begin
                if (out_free) begin
                    if (r_status == brf_pkg::STAT_OK) begin
                        case (r_cmd)
                            brf_pkg::CMD_PUT: begin
                                ram_we = 1'b1;
                                n_wp   = brf_pkg::ptr_add(r_wp, brf_pkg::CALC_W'(1));
                                n_fill = r_fill + brf_pkg::PTR_W'(1);
                            end
                            brf_pkg::CMD_GET: begin
                                n_rp   = brf_pkg::ptr_add(r_start, r_amt);
                                n_fill = brf_pkg::PTR_W'(r_avail - r_amt);
                            end
                            brf_pkg::CMD_SKIP: begin
                                n_rp   = brf_pkg::ptr_add(r_start, r_amt);
                                n_fill = r_fill - brf_pkg::PTR_W'(r_amt);
                            end
                            brf_pkg::CMD_CLEAR: begin
                                n_wp   = '0;
                                n_rp   = '0;
                                n_fill = '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (is_burst) begin
                        // first byte fetch; beats go out from the read state
                        ram_re    = 1'b1;
                        ram_raddr = r_start;
                        n_addr    = brf_pkg::ptr_add(r_start, brf_pkg::CALC_W'(1));
                        n_left    = brf_pkg::CNT_W'(r_amt);
                    end else begin
                        n_ovalid  = 1'b1;
                        n_odata   = '0;
                        n_odv     = 1'b0;
                        n_olast   = 1'b1;
                        n_ostatus = r_status;
                        n_oamt    = brf_pkg::AMT_W'(r_amt);
                        n_ofill   = brf_pkg::FILL_W'(n_fill);
                    end
                end
            end

            brf_pkg::ST_RDATA: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_odata   = ram_rdata;
                    n_odv     = 1'b1;
                    n_olast   = (r_left == brf_pkg::CNT_W'(1));
                    n_ostatus = brf_pkg::STAT_OK;
                    n_oamt    = brf_pkg::AMT_W'(r_amt);
                    n_ofill   = brf_pkg::FILL_W'(r_fill);
                    n_left    = r_left - brf_pkg::CNT_W'(1);
                    if (r_left != brf_pkg::CNT_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_addr;
                        n_addr    = brf_pkg::ptr_add(r_addr, brf_pkg::CALC_W'(1));
                    end
                end
            end

            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= brf_pkg::ST_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_din     <= n_din;
        r_status  <= n_status;
        r_amt     <= n_amt;
        r_start   <= n_start;
        r_avail   <= n_avail;
        r_addr    <= n_addr;
        r_odata   <= n_odata;
        r_odv     <= n_odv;
        r_olast   <= n_olast;
        r_ostatus <= n_ostatus;
        r_oamt    <= n_oamt;
        r_ofill   <= n_ofill;
    end

    assign o_stall      = (r_state != brf_pkg::ST_IDLE);
    assign o_valid      = r_ovalid;
    assign o_data_out   = r_odata;
    assign o_data_valid = r_odv;
    assign o_last       = r_olast;
    assign o_status     = r_ostatus;
    assign o_amount     = r_oamt;
    assign o_fill_level = r_ofill;

    // fill count tracks the pointer distance
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        brf_pkg::CALC_W'(r_fill) == brf_pkg::ptr_dist(r_wp, r_rp))
        else $error("fill count out of step with pointers");

    // no store writes while a burst is being read out
    a_no_write_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brf_pkg::ST_RDATA) |-> !ram_we)
        else $error("store write during burst read");

    a_burst_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brf_pkg::ST_RDATA) |-> (r_left != '0))
        else $error("burst read state with nothing left");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data_valid) |-> (o_status == brf_pkg::STAT_OK))
        else $error("data beat with error status");

    a_commit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == brf_pkg::ST_COMMIT))
        else $error("accepted command not committed next cycle");

endmodule
